### rtl/dbf_pkg.sv
package dbf_pkg;

    localparam int BYTE_W   = 8;
    localparam int ACTION_W = 3;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 6;
    localparam int FILL_W   = 7;

    localparam logic [ACTION_W-1:0] ACT_PUSH       = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_POP        = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_FIND       = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_READ_UNTIL = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_CLEAR      = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    localparam logic [BYTE_W-1:0] EMPTY_POP_BYTE = 8'hff;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_POP_OUT,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SCAN_DONE,
        S_EMIT_RD,
        S_EMIT_OUT
    } ctrl_state_t;

    typedef enum logic [2:0] {
        RES_STATUS,
        RES_POP_EMPTY,
        RES_POP,
        RES_FIND,
        RES_RUN
    } res_kind_t;

    typedef struct packed {
        logic                load_in;
        logic                rd_en;
        logic                wr_en;
        logic                cnt_inc;
        logic                drop_one;
        logic                drop_run;
        logic                clear;
        logic                idx_clr;
        logic                idx_inc;
        logic                scan_hit;
        logic                scan_miss;
        logic                out_load;
        res_kind_t           res_kind;
        logic [STATUS_W-1:0] res_status;
    } dbf_cmd_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                empty;
        logic                full;
        logic                match;
        logic                scan_last;
        logic                found;
        logic                pos_zero;
        logic                run_last;
        logic                out_free;
    } dbf_stat_t;

endpackage

### rtl/delimited_byte_fifo_top.sv
// A byte FIFO of DEPTH entries that also searches its contents for a byte.
// Each input beat carries one action: push, pop, find, read-until-delimiter
// or clear. Every action returns exactly one result beat with last set,
// except a read-until that finds its delimiter past the head, which returns
// one beat per byte ahead of the delimiter, the final one with last set, and
// then drops those bytes together with the delimiter. Every result beat
// carries the fill count as it stands once the action is complete. The
// block handles one action at a time. Push, clear and unused action codes
// finish in the dispatch state; a pop reads there and then loads its byte.
// Find and read-until walk the stored entries from the head through the
// single read port of the store, a read and a compare state per entry,
// and a read-until run then reads and loads each emitted byte in turn.
// A stalled result port holds the block at its next result; a new input
// beat is taken as soon as the previous action has loaded its final result,
// even while that result still waits to be taken. The store is a circular
// buffer with no reset of its own, so the block is ready right out of reset.

module delimited_byte_fifo_top import dbf_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [ACTION_W-1:0] s_action,
    input  logic [BYTE_W-1:0]   s_operand_byte,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [BYTE_W-1:0]   m_out_byte,
    output logic                m_byte_valid,
    output logic                m_last,
    output logic [STATUS_W-1:0] m_status,
    output logic [INDEX_W-1:0]  m_found_index,
    output logic [FILL_W-1:0]   m_fill_count
);

    // Commands flow from the controller to the datapath, status flows back.
    dbf_cmd_t  cmd;
    dbf_stat_t stat;

    dbf_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .stat   (stat),
        .cmd    (cmd)
    );

    // The datapath owns the store, the head and count, the scan index and
    // the result register that decouples the two ports.
    dbf_datapath #(
        .DEPTH(DEPTH)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_action      (s_action),
        .s_operand_byte(s_operand_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_byte_valid  (m_byte_valid),
        .m_last        (m_last),
        .m_status      (m_status),
        .m_found_index (m_found_index),
        .m_fill_count  (m_fill_count)
    );

endmodule

### rtl/dbf_ram.sv
module dbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/dbf_ctrl.sv
module dbf_ctrl import dbf_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  dbf_stat_t stat,
    output dbf_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (stat.action)
                    ACT_POP: begin
                        if (!stat.empty) begin
                            state_next = S_POP_OUT;
                        end else if (stat.out_free) begin
                            state_next = S_IDLE;
                        end
                    end
                    ACT_FIND, ACT_READ_UNTIL: begin
                        if (!stat.empty) begin
                            state_next = S_SCAN_CMP;
                        end else if (stat.out_free) begin
                            state_next = S_IDLE;
                        end
                    end
                    default: begin
                        if (stat.out_free) begin
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end
            S_POP_OUT: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN_RD: begin
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (stat.match || stat.scan_last) begin
                    state_next = S_SCAN_DONE;
                end else begin
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_DONE: begin
                if (stat.action == ACT_READ_UNTIL && stat.found && !stat.pos_zero) begin
                    state_next = S_EMIT_RD;
                end else if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT_RD: begin
                state_next = S_EMIT_OUT;
            end
            S_EMIT_OUT: begin
                if (stat.out_free) begin
                    state_next = stat.run_last ? S_IDLE : S_EMIT_RD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        s_ready        = 1'b0;
        cmd            = '0;
        cmd.res_kind   = RES_STATUS;
        cmd.res_status = ST_OK;
        case (state_reg)
            S_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
            end
            S_DISPATCH: begin
                case (stat.action)
                    ACT_PUSH: begin
                        if (stat.out_free) begin
                            cmd.out_load = 1'b1;
                            if (stat.full) begin
                                cmd.res_status = ST_FULL;
                            end else begin
                                cmd.wr_en   = 1'b1;
                                cmd.cnt_inc = 1'b1;
                            end
                        end
                    end
                    ACT_POP: begin
                        if (!stat.empty) begin
                            cmd.rd_en = 1'b1;
                        end else if (stat.out_free) begin
                            cmd.out_load = 1'b1;
                            cmd.res_kind = RES_POP_EMPTY;
                        end
                    end
                    ACT_FIND, ACT_READ_UNTIL: begin
                        if (!stat.empty) begin
                            cmd.rd_en = 1'b1;
                        end else if (stat.out_free) begin
                            cmd.out_load   = 1'b1;
                            cmd.res_status = ST_EMPTY;
                        end
                    end
                    ACT_CLEAR: begin
                        if (stat.out_free) begin
                            cmd.out_load = 1'b1;
                            cmd.clear    = 1'b1;
                        end
                    end
                    default: begin
                        cmd.out_load = stat.out_free;
                    end
                endcase
            end
            S_POP_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.res_kind = RES_POP;
                    cmd.drop_one = 1'b1;
                end
            end
            S_SCAN_RD: begin
                cmd.rd_en = 1'b1;
            end
            S_SCAN_CMP: begin
                if (stat.match) begin
                    cmd.scan_hit = 1'b1;
                end else if (stat.scan_last) begin
                    cmd.scan_miss = 1'b1;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_SCAN_DONE: begin
                if (stat.action == ACT_READ_UNTIL && stat.found && !stat.pos_zero) begin
                    cmd.idx_clr = 1'b1;
                end else if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    if (!stat.found) begin
                        cmd.res_status = ST_NOT_FOUND;
                    end else if (stat.action == ACT_FIND) begin
                        cmd.res_kind = RES_FIND;
                    end else begin
                        cmd.drop_run = 1'b1;
                    end
                end
            end
            S_EMIT_RD: begin
                cmd.rd_en = 1'b1;
            end
            S_EMIT_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.res_kind = RES_RUN;
                    if (stat.run_last) begin
                        cmd.drop_run = 1'b1;
                    end else begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

### rtl/dbf_datapath.sv
module dbf_datapath import dbf_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  dbf_cmd_t            cmd,
    output dbf_stat_t           stat,
    input  logic [ACTION_W-1:0] s_action,
    input  logic [BYTE_W-1:0]   s_operand_byte,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [BYTE_W-1:0]   m_out_byte,
    output logic                m_byte_valid,
    output logic                m_last,
    output logic [STATUS_W-1:0] m_status,
    output logic [INDEX_W-1:0]  m_found_index,
    output logic [FILL_W-1:0]   m_fill_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic [ACTION_W-1:0] action_reg;
    logic [BYTE_W-1:0]   operand_reg;
    logic [AW-1:0]       head_reg, head_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [AW-1:0]       pos_reg;
    logic                found_reg;
    logic                m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0]   out_byte_reg, out_byte_next;
    logic                byte_valid_reg, byte_valid_next;
    logic                last_reg, last_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [INDEX_W-1:0]  found_index_reg, found_index_next;
    logic [FILL_W-1:0]   fill_count_reg, fill_count_next;

    logic [BYTE_W-1:0] rdata;
    logic [CW-1:0]     rd_sum, wr_sum, run_sum;
    logic [AW-1:0]     rd_addr, wr_addr, run_head;
    logic [CW-1:0]     run_fill;
    logic              out_free;

    // Circular addressing: the sum of two in-range terms stays below twice
    // the depth, so a single conditional subtract wraps it.
    assign rd_sum   = {1'b0, head_reg} + {1'b0, idx_reg};
    assign rd_addr  = AW'((rd_sum >= DEPTH_C) ? rd_sum - DEPTH_C : rd_sum);
    assign wr_sum   = {1'b0, head_reg} + {1'b0, AW'(count_reg)};
    assign wr_addr  = AW'((wr_sum >= DEPTH_C) ? wr_sum - DEPTH_C : wr_sum);
    assign run_sum  = {1'b0, head_reg} + {1'b0, pos_reg} + CW'(1);
    assign run_head = AW'((run_sum >= DEPTH_C) ? run_sum - DEPTH_C : run_sum);
    assign run_fill = count_reg - {1'b0, pos_reg} - CW'(1);
    assign out_free = !m_valid_reg || m_ready;

    dbf_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(DEPTH)
    ) u_store (
        .clk  (aclk),
        .we   (cmd.wr_en),
        .waddr(wr_addr),
        .wdata(operand_reg),
        .re   (cmd.rd_en),
        .raddr(rd_addr),
        .rdata(rdata)
    );

    always_comb begin
        stat.action    = action_reg;
        stat.empty     = (count_reg == '0);
        stat.full      = (count_reg == DEPTH_C);
        stat.match     = (rdata == operand_reg);
        stat.scan_last = (({1'b0, idx_reg} + CW'(1)) == count_reg);
        stat.found     = found_reg;
        stat.pos_zero  = (pos_reg == '0);
        stat.run_last  = (({1'b0, idx_reg} + CW'(1)) == {1'b0, pos_reg});
        stat.out_free  = out_free;
    end

    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        if (cmd.clear) begin
            head_next  = '0;
            count_next = '0;
        end else if (cmd.cnt_inc) begin
            count_next = count_reg + CW'(1);
        end else if (cmd.drop_one) begin
            head_next  = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
            count_next = count_reg - CW'(1);
        end else if (cmd.drop_run) begin
            head_next  = run_head;
            count_next = run_fill;
        end
    end

    always_comb begin
        idx_next = idx_reg;
        if (cmd.load_in || cmd.idx_clr) begin
            idx_next = '0;
        end else if (cmd.idx_inc) begin
            idx_next = idx_reg + AW'(1);
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Next contents of the result register.
    always_comb begin
        out_byte_next    = out_byte_reg;
        byte_valid_next  = byte_valid_reg;
        last_next        = last_reg;
        status_next      = status_reg;
        found_index_next = found_index_reg;
        fill_count_next  = fill_count_reg;
        if (cmd.out_load) begin
            out_byte_next    = '0;
            byte_valid_next  = 1'b0;
            last_next        = 1'b1;
            status_next      = ST_OK;
            found_index_next = '0;
            fill_count_next  = FILL_W'(count_next);
            case (cmd.res_kind)
                RES_STATUS: begin
                    status_next = cmd.res_status;
                end
                RES_POP_EMPTY: begin
                    out_byte_next = EMPTY_POP_BYTE;
                    status_next   = ST_EMPTY;
                end
                RES_POP: begin
                    out_byte_next   = rdata;
                    byte_valid_next = 1'b1;
                end
                RES_FIND: begin
                    found_index_next = INDEX_W'(pos_reg);
                end
                RES_RUN: begin
                    out_byte_next   = rdata;
                    byte_valid_next = 1'b1;
                    last_next       = stat.run_last;
                    fill_count_next = FILL_W'(run_fill);
                end
                default: begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            count_reg   <= '0;
            idx_reg     <= '0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            head_reg    <= head_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
            if (cmd.scan_hit) begin
                found_reg <= 1'b1;
            end else if (cmd.scan_miss) begin
                found_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            action_reg  <= s_action;
            operand_reg <= s_operand_byte;
        end
        if (cmd.scan_hit) begin
            pos_reg <= idx_reg;
        end
        out_byte_reg    <= out_byte_next;
        byte_valid_reg  <= byte_valid_next;
        last_reg        <= last_next;
        status_reg      <= status_next;
        found_index_reg <= found_index_next;
        fill_count_reg  <= fill_count_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = out_byte_reg;
    assign m_byte_valid  = byte_valid_reg;
    assign m_last        = last_reg;
    assign m_status      = status_reg;
    assign m_found_index = found_index_reg;
    assign m_fill_count  = fill_count_reg;

    // The fill count never passes the depth.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("fill count above depth");

    // A result is loaded only into a free output register.
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> out_free)
        else $error("result register overwritten");

    // A write is never issued into a full store.
    a_no_write_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_en |-> (count_reg < DEPTH_C))
        else $error("write into full store");

    // A read is only of a stored entry.
    a_read_stored: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_en |-> ({1'b0, idx_reg} < count_reg))
        else $error("read beyond stored entries");

    // Every drop leaves the fill count lower than before.
    a_drop_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.drop_one || cmd.drop_run) |=> (count_reg < $past(count_reg)))
        else $error("drop did not shrink the store");

endmodule
